FILE: sv/ssms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_pkg: shared definitions for the shared-store multi-stack core
// Widths of the transaction fields, default sizes and the command and status
// codes.
// ----------------------------------------------------------------------------
package ssms_pkg;

  localparam int NUM_STACKS_DEF  = 4;
  localparam int STORE_DEPTH_DEF = 16;

  localparam int DATA_W     = 32;
  localparam int STACK_ID_W = 2;
  localparam int STATUS_W   = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

FILE: sv/ssms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssms_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module ssms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/shared_store_multi_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_store_multi_stack_core: several LIFO stacks in one shared store
// Stacks are linked chains in a slot memory; free slots form a linked free
// list. Push and pop each return one result transaction.
// ----------------------------------------------------------------------------
// Usage: a push, or any command that is rejected (overflow, underflow, or a
// stack id at or above NUM_STACKS), runs the idle and top-pointer steps before
// the next acceptance; a successful pop adds a slot read step. The steps follow
// the dependent memory reads: the stack top pointer comes from one memory, and
// a pop must then read the data and link of that slot from the slot memory.
// The result sits in an output register, so a new command is accepted while
// the previous result waits; a result that cannot be delivered holds the core
// in its last step. No clearing pass is needed after reset: never-used slots
// are tracked by a fill count and stack tops by valid bits.
// ----------------------------------------------------------------------------
module shared_store_multi_stack_core
  import ssms_pkg::*;
#(
  parameter int NUM_STACKS  = NUM_STACKS_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic                       command,
  input  logic [STACK_ID_W-1:0]      stack_id,
  input  logic signed [DATA_W-1:0]   value,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic signed [DATA_W-1:0]   data,
  output logic [STATUS_W-1:0]        status,
  output logic                       store_full,
  output logic                       stack_empty
);

  localparam int PW  = $clog2(STORE_DEPTH + 1);
  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int SIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SW  = DATA_W + PW;
  localparam logic [PW-1:0] NIL = PW'(STORE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TOP  = 3'b010,
    ST_SLOT = 3'b100
  } state_t;

  state_t state, state_next;

  logic                     cmd_q;
  logic [SIW-1:0]           sid_q;
  logic                     sid_ok_q;
  logic [DATA_W-1:0]        value_q;
  logic [PW-1:0]            pop_slot;
  logic [PW-1:0]            pop_slot_next;
  logic [PW-1:0]            free_head, free_head_next;
  logic [PW-1:0]            fresh, fresh_next;
  logic [NUM_STACKS-1:0]    top_valid, top_valid_next;

  logic                     top_we, top_re;
  logic [SIW-1:0]           top_raddr;
  logic [PW-1:0]            top_wdata, top_rdata;
  logic                     slot_we, slot_re;
  logic [AW-1:0]            slot_waddr, slot_raddr;
  logic [SW-1:0]            slot_wdata, slot_rdata;

  logic                     res_load;
  logic [DATA_W-1:0]        res_data;
  logic [STATUS_W-1:0]      res_status;
  logic                     res_empty;

  logic                     accept;
  logic                     rsp_free;
  logic [SIW-1:0]           sid_idx;
  logic                     sid_ok;
  logic [PW-1:0]            top_ptr;
  logic [PW-1:0]            head_link;
  logic [PW-1:0]            slot_link;

  assign sid_idx   = SIW'(stack_id);
  assign sid_ok    = ({{(32-STACK_ID_W){1'b0}}, stack_id} < 32'(NUM_STACKS));
  assign cmd_ready = (state == ST_IDLE);
  assign accept    = cmd_valid && cmd_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  assign top_ptr   = top_valid[sid_q] ? top_rdata : NIL;
  // A slot never taken before holds no stored link; its link to the next slot is taken as fresh + 1.
  assign head_link = (free_head == fresh) ? (fresh + PW'(1)) : slot_rdata[PW-1:0];
  assign slot_link = slot_rdata[PW-1:0];

  ssms_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_STACKS)
  ) u_top_ram (
    .clk  (clk),
    .we   (top_we),
    .waddr(sid_q),
    .wdata(top_wdata),
    .re   (top_re),
    .raddr(top_raddr),
    .rdata(top_rdata)
  );

  ssms_ram #(
    .WIDTH(SW),
    .DEPTH(STORE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    fresh_next     = fresh;
    top_valid_next = top_valid;
    pop_slot_next  = pop_slot;
    top_re         = 1'b0;
    top_raddr      = sid_idx;
    top_we         = 1'b0;
    top_wdata      = free_head;
    slot_re        = 1'b0;
    slot_raddr     = free_head[AW-1:0];
    slot_we        = 1'b0;
    slot_waddr     = free_head[AW-1:0];
    slot_wdata     = {value_q, top_ptr};
    res_load       = 1'b0;
    res_data       = '0;
    res_status     = STATUS_OK;
    res_empty      = 1'b1;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          top_re  = sid_ok;
          // Fetch the free head's link now; a push needs it in the top-pointer step.
          slot_re = (free_head != NIL);
          state_next = ST_TOP;
        end
      end
      ST_TOP: begin
        if (!sid_ok_q) begin
          if (rsp_free) begin
            res_load   = 1'b1;
            res_data   = (cmd_q == CMD_POP) ? '1 : '0;
            res_status = (cmd_q == CMD_POP) ? STATUS_UNDERFLOW : STATUS_OVERFLOW;
            state_next = ST_IDLE;
          end
        end else if (cmd_q == CMD_PUSH) begin
          if (rsp_free) begin
            res_load = 1'b1;
            state_next = ST_IDLE;
            if (free_head == NIL) begin
              res_status = STATUS_OVERFLOW;
              res_empty  = (top_ptr == NIL);
            end else begin
              slot_we   = 1'b1;
              top_we    = 1'b1;
              top_valid_next[sid_q] = 1'b1;
              free_head_next = head_link;
              if (free_head == fresh) begin
                fresh_next = fresh + PW'(1);
              end
              res_empty = 1'b0;
            end
          end
        end else begin
          if (top_ptr == NIL) begin
            if (rsp_free) begin
              res_load   = 1'b1;
              res_data   = '1;
              res_status = STATUS_UNDERFLOW;
              state_next = ST_IDLE;
            end
          end else begin
            slot_re       = 1'b1;
            slot_raddr    = top_ptr[AW-1:0];
            pop_slot_next = top_ptr;
            state_next    = ST_SLOT;
          end
        end
      end
      ST_SLOT: begin
        if (rsp_free) begin
          res_load   = 1'b1;
          res_data   = slot_rdata[SW-1:PW];
          res_empty  = (slot_link == NIL);
          top_we     = 1'b1;
          top_wdata  = slot_link;
          slot_we    = 1'b1;
          slot_waddr = pop_slot[AW-1:0];
          slot_wdata = {slot_rdata[SW-1:PW], free_head};
          free_head_next = pop_slot;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      free_head <= '0;
      fresh     <= '0;
      top_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      top_valid <= top_valid_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pop_slot <= pop_slot_next;
    if (accept) begin
      cmd_q    <= command;
      sid_q    <= sid_idx;
      sid_ok_q <= sid_ok;
      value_q  <= value;
    end
    if (res_load) begin
      data        <= res_data;
      status      <= res_status;
      store_full  <= (free_head_next == NIL);
      stack_empty <= res_empty;
    end
  end

  a_free_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= NIL)
    else $error("free list head out of range");

  a_fresh_implies_free: assert property (@(posedge clk) disable iff (rst)
    fresh != NIL |-> free_head != NIL)
    else $error("unused slots remain but the free list is empty");

  a_underflow_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_UNDERFLOW |-> stack_empty && data == '1)
    else $error("underflow result without empty stack and all-ones data");

  a_slot_only_pop: assert property (@(posedge clk) disable iff (rst)
    state == ST_SLOT |-> cmd_q == CMD_POP && sid_ok_q)
    else $error("slot read step entered for a command other than a valid pop");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> !$past(res_load) || $past(rsp_free))
    else $error("result overwritten while waiting");

endmodule
